[rtl/core/ubsd_pkg.sv]
// Shared types and constants for the byte-stream character decoder.
`timescale 1ns / 1ps
`default_nettype none

package ubsd_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CP_W    = 32;
  localparam int unsigned PEND_W  = 2;
  localparam int unsigned MODE_W  = 2;

  // Encoding select codes
  localparam logic [MODE_W-1:0] MODE_UTF8    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_UTF16BE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_UTF32BE = 2'd2;

  localparam logic [CP_W-1:0] REPLACEMENT_CHAR   = 32'h0000_FFFD;
  localparam logic [CP_W-1:0] SUPPLEMENTARY_BASE = 32'h0001_0000;
  localparam logic [15:0]     SURR_LO            = 16'hD800;
  localparam logic [15:0]     SURR_HI            = 16'hDFFF;

  localparam logic [BYTE_W-1:0] ASCII_MAX     = 8'h7F;
  localparam logic [BYTE_W-1:0] LEAD2_MAX     = 8'hDF;
  localparam logic [BYTE_W-1:0] LEAD3_MAX     = 8'hEF;

  // Result of one decode pass over a byte
  typedef struct packed {
    logic [PEND_W-1:0] pending_next;
    logic [CP_W-1:0]   acc_next;
    logic              emit;
    logic [CP_W-1:0]   code_point;
    logic              replaced;
  } decode_t;

endpackage : ubsd_pkg

`default_nettype wire

[rtl/core/ubsd_decode.sv]
// Per-byte decode logic: next sequence state and optional code point.
`timescale 1ns / 1ps
`default_nettype none

module ubsd_decode
  import ubsd_pkg::*;
(
  input  wire logic [MODE_W-1:0] mode,
  input  wire logic [PEND_W-1:0] pending,
  input  wire logic [CP_W-1:0]   acc,
  input  wire logic [BYTE_W-1:0] byte_in,
  output decode_t                res
);

  logic [PEND_W-1:0] pend_dec;
  logic [CP_W-1:0]   unit16;
  logic [CP_W-1:0]   pair_sum;
  logic [CP_W-1:0]   cont8;
  logic [CP_W-1:0]   part32;

  assign pend_dec = pending - PEND_W'(1);
  assign unit16   = acc | {24'd0, byte_in};
  assign pair_sum = unit16 + SUPPLEMENTARY_BASE;

  // Six payload bits of a UTF-8 continuation byte at their place
  always_comb begin
    case (pend_dec)
      2'd0:    cont8 = {26'd0, byte_in[5:0]};
      2'd1:    cont8 = {20'd0, byte_in[5:0], 6'd0};
      2'd2:    cont8 = {14'd0, byte_in[5:0], 12'd0};
      default: cont8 = {8'd0, byte_in[5:0], 18'd0};
    endcase
  end

  // One byte of a UTF-32 word at its place
  always_comb begin
    case (pend_dec)
      2'd0:    part32 = {24'd0, byte_in};
      2'd1:    part32 = {16'd0, byte_in, 8'd0};
      2'd2:    part32 = {8'd0, byte_in, 16'd0};
      default: part32 = {byte_in, 24'd0};
    endcase
  end

  always_comb begin
    res              = '0;
    res.pending_next = pending;
    res.acc_next     = acc;
    case (mode)
      MODE_UTF8: begin
        if (pending == '0) begin
          if (byte_in <= ASCII_MAX) begin
            res.emit       = 1'b1;
            res.code_point = {24'd0, byte_in};
          end else if (byte_in <= LEAD2_MAX) begin
            res.acc_next     = {21'd0, byte_in[4:0], 6'd0};
            res.pending_next = 2'd1;
          end else if (byte_in <= LEAD3_MAX) begin
            res.acc_next     = {16'd0, byte_in[3:0], 12'd0};
            res.pending_next = 2'd2;
          end else begin
            res.acc_next     = {11'd0, byte_in[2:0], 18'd0};
            res.pending_next = 2'd3;
          end
        end else if (byte_in[7:6] == 2'b10) begin
          res.acc_next     = acc | cont8;
          res.pending_next = pend_dec;
          res.emit         = (pend_dec == '0);
          res.code_point   = acc | cont8;
        end else begin
          // broken sequence: drop it and substitute
          res.acc_next     = REPLACEMENT_CHAR;
          res.pending_next = '0;
          res.emit         = 1'b1;
          res.code_point   = REPLACEMENT_CHAR;
          res.replaced     = 1'b1;
        end
      end
      MODE_UTF16BE: begin
        case (pending)
          2'd0: begin
            res.acc_next     = {16'd0, byte_in, 8'd0};
            res.pending_next = 2'd1;
          end
          2'd1: begin
            if (unit16 >= {16'd0, SURR_LO} && unit16 <= {16'd0, SURR_HI}) begin
              res.acc_next     = {12'd0, unit16[9:0], 10'd0};
              res.pending_next = 2'd3;
            end else begin
              res.acc_next     = unit16;
              res.pending_next = '0;
              res.emit         = 1'b1;
              res.code_point   = unit16;
            end
          end
          2'd3: begin
            res.acc_next     = acc | {22'd0, byte_in[1:0], 8'd0};
            res.pending_next = 2'd2;
          end
          default: begin
            res.acc_next     = pair_sum;
            res.pending_next = '0;
            res.emit         = 1'b1;
            res.code_point   = pair_sum;
          end
        endcase
      end
      MODE_UTF32BE: begin
        if (pending == '0) begin
          res.acc_next     = {byte_in, 24'd0};
          res.pending_next = 2'd3;
        end else begin
          res.acc_next     = acc | part32;
          res.pending_next = pend_dec;
          res.emit         = (pend_dec == '0);
          res.code_point   = acc | part32;
        end
      end
      default: begin
        res.emit = 1'b0;
      end
    endcase
  end

endmodule : ubsd_decode

`default_nettype wire

[rtl/core/ubsd_out_stage.sv]
// Result register with stream handshake toward the consumer.
`timescale 1ns / 1ps
`default_nettype none

module ubsd_out_stage
  import ubsd_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            load,
  input  wire logic [CP_W-1:0] code_point,
  input  wire logic            replaced,
  output logic                 free,
  output logic                 m_axis_tvalid,
  input  wire logic            m_axis_tready,
  output logic [CP_W-1:0]      m_axis_tdata,
  output logic [0:0]           m_axis_tuser
);

  assign free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // hold payload until the beat is taken
  always_ff @(posedge clk) begin
    if (load) begin
      m_axis_tdata <= code_point;
      m_axis_tuser <= replaced;
    end
  end

endmodule : ubsd_out_stage

`default_nettype wire

[rtl/core/unicode_byte_stream_decoder_core.sv]
// Top level of the byte-stream character decoder (UTF-8 / UTF-16BE / UTF-32BE).
//
//   channel   direction  handshake                     payload
//   s_axis    in         s_axis_tvalid/s_axis_tready   tdata[7:0] byte_in
//   m_axis    out        m_axis_tvalid/m_axis_tready   tdata[31:0] code_point,
//                                                      tuser[0] replaced
//   cfg       in         cfg_valid/cfg_ready           cfg_data[1:0] encoding_mode
//
// One byte per cycle sustained unless a completing byte waits for the result
// slot. A byte is held in the input register, then the decode pass updates the
// sequence state and loads the result register, from which the code point of
// a sequence's last byte shows on m_axis.
// Bytes that complete nothing keep flowing while the result register stalls;
// a completing byte waits in the input register until the result slot frees.
// rst (synchronous) clears both valid flags, the sequence state and the mode.
// cfg_ready is always high; a mode write also abandons any open sequence.
`timescale 1ns / 1ps
`default_nettype none

module unicode_byte_stream_decoder_core
  import ubsd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  // byte stream in
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [BYTE_W-1:0] s_axis_tdata,   // [7:0] byte_in
  // code points out
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic [CP_W-1:0]        m_axis_tdata,   // [31:0] code_point
  output logic [0:0]             m_axis_tuser,   // [0] replaced
  // mode register write
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [MODE_W-1:0] cfg_data
);

  // Input register
  logic              in_vld;
  logic [BYTE_W-1:0] in_byte;

  // Sequence state
  logic [MODE_W-1:0] mode;
  logic [PEND_W-1:0] pending;
  logic [CP_W-1:0]   acc;

  decode_t dec;
  logic    out_free;
  logic    fire;

  assign cfg_ready = 1'b1;

  // Advance the held byte unless it has a result and the result slot is full.
  assign fire          = in_vld && (out_free || !dec.emit);
  assign s_axis_tready = !in_vld || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready) begin
      in_byte <= s_axis_tdata;
    end
  end

  ubsd_decode u_decode (
    .mode    (mode),
    .pending (pending),
    .acc     (acc),
    .byte_in (in_byte),
    .res     (dec)
  );

  // Mode write wins and drops any partial sequence.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_UTF8;
      pending <= '0;
      acc     <= '0;
    end else if (cfg_valid) begin
      mode    <= cfg_data;
      pending <= '0;
      acc     <= '0;
    end else if (fire) begin
      pending <= dec.pending_next;
      acc     <= dec.acc_next;
    end
  end

  ubsd_out_stage u_out (
    .clk           (clk),
    .rst           (rst),
    .load          (fire && dec.emit),
    .code_point    (dec.code_point),
    .replaced      (dec.replaced),
    .free          (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule : unicode_byte_stream_decoder_core

`default_nettype wire

[rtl/core/ubsd_checker.sv]
// Port-level assertions for the decoder top level, with bind.
`timescale 1ns / 1ps
`default_nettype none

module ubsd_checker
  import ubsd_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              s_axis_tready,
  input wire logic              m_axis_tvalid,
  input wire logic              m_axis_tready,
  input wire logic [CP_W-1:0]   m_axis_tdata,
  input wire logic [0:0]        m_axis_tuser
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  // a replaced flag always comes with U+FFFD
  a_repl_value: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == REPLACEMENT_CHAR)
    else $error("replaced beat without replacement character");

  // input backpressure only while the result side is stalled
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled with result slot free");

  // reset empties the result register
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

endmodule : ubsd_checker

bind unicode_byte_stream_decoder_core ubsd_checker u_ubsd_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
